### rtl/core/modular_exponentiation_core_defines.svh
// Assertion macros for the modular exponentiation core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Generic clocked check with a synchronous active-low reset as disable.
`define MEXP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the core clock and reset.
`define MEXP_ASSERT(label, prop, msg) \
    `MEXP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### rtl/core/mexp_pkg.sv
// Shared constants and types for the modular exponentiation core.
// No dependencies; used by the multiply-reduce unit and the top level.
package mexp_pkg;

    localparam int FIELD_W = 63;
    localparam int CNT_W   = $clog2(FIELD_W);

    localparam logic [FIELD_W-1:0] MOD_RESET  = 63'd409120391;
    localparam logic [FIELD_W-1:0] FIELD_ONE  = 63'd1;
    localparam logic [CNT_W-1:0]   LAST_STEP  = CNT_W'(FIELD_W - 1);

    // Request to the multiply-reduce unit: result = (a * b) mod m, a < m or a == 1.
    typedef struct packed {
        logic               start;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
    } t_mm_cmd;

    typedef struct packed {
        logic               done;
        logic [FIELD_W-1:0] result;
    } t_mm_rsp;

endpackage

### rtl/core/mexp_in_if.sv
// Input channel of the modular exponentiation core: base and exponent.
// Depends on mexp_pkg for the field width.
interface mexp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::FIELD_W-1:0] base_value;
    logic [mexp_pkg::FIELD_W-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

### rtl/core/mexp_out_if.sv
// Output channel of the modular exponentiation core: the power result.
// Depends on mexp_pkg for the field width.
interface mexp_out_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::FIELD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

### rtl/core/mexp_mulmod.sv
// Bit-serial multiply-reduce unit: (a * b) mod m by double-and-add, one bit of b a cycle.
// Depends on mexp_pkg for the command and response types.
module mexp_mulmod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mexp_pkg::FIELD_W-1:0] i_modulus,
    input  mexp_pkg::t_mm_cmd            i_cmd,
    output mexp_pkg::t_mm_rsp            o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [mexp_pkg::CNT_W-1:0]   r_cnt;
    logic [mexp_pkg::FIELD_W-1:0] r_a;
    logic [mexp_pkg::FIELD_W-1:0] r_b;
    logic [mexp_pkg::FIELD_W-1:0] r_r;
    logic [mexp_pkg::FIELD_W-1:0] n_r;

    logic [mexp_pkg::FIELD_W+1:0] w_sum;
    logic [mexp_pkg::FIELD_W+1:0] w_m1;
    logic [mexp_pkg::FIELD_W+1:0] w_m2;

    // 2r + a*bit stays below 3m, so at most two subtractions of m are needed;
    // both compares run side by side.
    always_comb begin
        w_m1  = {2'b00, i_modulus};
        w_m2  = {1'b0, i_modulus, 1'b0};
        w_sum = {1'b0, r_r, 1'b0}
              + (r_b[mexp_pkg::FIELD_W-1] ? {2'b00, r_a} : '0);
        if (w_sum >= w_m2) begin
            n_r = mexp_pkg::FIELD_W'(w_sum - w_m2);
        end else if (w_sum >= w_m1) begin
            n_r = mexp_pkg::FIELD_W'(w_sum - w_m1);
        end else begin
            n_r = mexp_pkg::FIELD_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mexp_pkg::LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= i_cmd.a;
            r_b <= i_cmd.b;
            r_r <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[mexp_pkg::FIELD_W-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

endmodule

### rtl/core/modular_exponentiation_core.sv
// Channel    Dir  Handshake      Payload
// i_in       in   valid/ready    base_value[62:0], exponent[62:0]
// o_out      out  valid/ready    power_result[62:0]
// i_cfg_*    in   write enable   modulus[62:0]
//
// One item at a time: each modular multiply runs in the shared bit-serial unit, and
// reducing the base is one such multiply. An item takes n + p + 2 multiplies from acceptance
// to a valid result, n the position of the top set exponent bit and p the set bits below it;
// a zero exponent takes none. The input is ready again in the same cycle that the result
// becomes valid. Reset is synchronous; the modulus returns to 409120391. A finished result
// waits in the output register while the next item is worked; that item then holds in
// dispatch, and the input stalls, until it frees.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_mulmod and the defines header.
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core #(
    parameter int OPERAND_BITS = 63
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mexp_pkg::FIELD_W-1:0] i_cfg_wdata,
    mexp_in_if.sink                      i_in,
    mexp_out_if.source                   o_out
);

    localparam logic [mexp_pkg::FIELD_W-1:0] OP_MASK =
        (mexp_pkg::FIELD_ONE << OPERAND_BITS) - mexp_pkg::FIELD_ONE;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_NEXT   = 5'b00100,
        S_MUL    = 5'b01000,
        S_SQR    = 5'b10000
    } t_state;

    t_state                       r_state;
    logic                         r_pend;
    logic [mexp_pkg::FIELD_W-1:0] r_modulus;
    logic [mexp_pkg::FIELD_W-1:0] r_acc;
    logic [mexp_pkg::FIELD_W-1:0] r_sq;
    logic [OPERAND_BITS-1:0]      r_exp;
    logic                         r_out_valid;
    logic [mexp_pkg::FIELD_W-1:0] r_out_data;

    logic [mexp_pkg::FIELD_W-1:0] w_cfg_masked;
    logic [mexp_pkg::FIELD_W-1:0] w_base_masked;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_finish;
    logic                         w_in_wait;
    mexp_pkg::t_mm_cmd            w_cmd;
    mexp_pkg::t_mm_rsp            w_rsp;

    assign w_cfg_masked  = i_cfg_wdata & OP_MASK;
    assign w_base_masked = i_in.base_value & OP_MASK;
    assign w_accept      = i_in.valid && i_in.ready;
    assign w_out_free    = !r_out_valid || o_out.ready;
    assign w_finish      = (r_state == S_NEXT) && (r_exp == '0) && w_out_free;
    assign w_in_wait     = (r_state == S_REDUCE) || (r_state == S_MUL) || (r_state == S_SQR);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.power_result = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= (w_cfg_masked == '0) ? mexp_pkg::FIELD_ONE : w_cfg_masked;
        end
    end

    // Reducing the base is a multiply by one, so the same unit does it.
    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.a     = r_sq;
        w_cmd.b     = r_sq;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.start = w_accept && (i_in.exponent[OPERAND_BITS-1:0] != '0);
                w_cmd.a     = mexp_pkg::FIELD_ONE;
                w_cmd.b     = w_base_masked;
            end
            S_NEXT: begin
                w_cmd.start = (r_exp != '0);
                w_cmd.b     = r_exp[0] ? r_acc : r_sq;
            end
            S_REDUCE, S_MUL, S_SQR: begin
                w_cmd.start = 1'b0;
            end
            default: begin
                w_cmd.start = 1'b0;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_cmd     (w_cmd),
        .o_rsp     (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // r_pend marks a finished result that could not yet enter the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (i_in.exponent[OPERAND_BITS-1:0] != '0) ? S_REDUCE : S_NEXT;
                    end
                end
                S_REDUCE: begin
                    if (w_rsp.done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_exp != '0) begin
                        r_state <= r_exp[0] ? S_MUL : S_SQR;
                    end else if (w_out_free) begin
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_pend <= 1'b1;
                    end
                end
                S_MUL, S_SQR: begin
                    if (w_rsp.done) begin
                        r_state <= S_NEXT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_acc <= mexp_pkg::FIELD_ONE;
                    r_exp <= i_in.exponent[OPERAND_BITS-1:0];
                end
            end
            S_REDUCE: begin
                if (w_rsp.done) begin
                    r_sq <= w_rsp.result;
                end
            end
            S_NEXT: begin
                if ((r_exp == '0) && w_out_free) begin
                    r_out_data <= r_acc;
                end
            end
            S_MUL: begin
                // Clearing the low bit lets the next dispatch square or finish.
                if (w_rsp.done) begin
                    r_acc    <= w_rsp.result;
                    r_exp[0] <= 1'b0;
                end
            end
            S_SQR: begin
                if (w_rsp.done) begin
                    r_sq  <= w_rsp.result;
                    r_exp <= r_exp >> 1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    `MEXP_ASSERT(a_done_in_wait, (w_rsp.done |-> w_in_wait), "multiply done outside a wait")
    `MEXP_ASSERT(a_modulus_nonzero, (r_modulus != '0), "modulus register holds zero")
    `MEXP_ASSERT(a_out_from_next, ($rose(r_out_valid) |-> $past(w_finish)), "stray result")
    `MEXP_ASSERT(a_pend_holds, (r_pend |-> (r_state == S_NEXT)), "stray pending flag")

endmodule

### tb/tb_modular_exponentiation_core.sv
// Testbench for modular_exponentiation_core: sends base/exponent items under several moduli
// and checks every power result against a typed value or a local square-and-multiply predictor.
// Depends on mexp_pkg and the mexp_in_if / mexp_out_if interfaces of the RTL.
module tb_modular_exponentiation_core;

    localparam int W = mexp_pkg::FIELD_W;
    localparam logic [W-1:0] MOD_AT_RESET = mexp_pkg::MOD_RESET;
    localparam logic [W-1:0] ALL_ONES     = '1;
    localparam logic [W-1:0] ODD_BITS     = 63'h5555_5555_5555_5555;
    localparam logic [W-1:0] EVEN_BITS    = 63'h2AAA_AAAA_AAAA_AAAA;
    localparam int N_DIRECTED    = 15;
    localparam int N_PHASES      = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 8000;
    localparam int IDLE_LIMIT    = 40000;

    typedef struct packed {
        logic [W-1:0] base_value;
        logic [W-1:0] exponent;
        logic         known;
        logic [W-1:0] power;
    } t_stim_row;

    typedef struct {
        logic [W-1:0] base_value;
        logic [W-1:0] exponent;
        logic [W-1:0] modulus;
        logic [W-1:0] power;
    } t_power_entry;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [W-1:0] i_cfg_wdata;

    mexp_in_if  in_ch ();
    mexp_out_if out_ch ();

    modular_exponentiation_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_power_entry pending_powers[$];
    logic [W-1:0] modulus_shadow;
    int           error_count;
    bit           hold_request;
    bit           send_steady;
    bit           recv_steady;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // (a * b) mod m at full double width.
    function automatic logic [W-1:0] mul_reduce(input logic [W-1:0] a, input logic [W-1:0] b,
                                                input logic [W-1:0] m);
        logic [2*W-1:0] wa;
        logic [2*W-1:0] wb;
        logic [2*W-1:0] wm;
        logic [2*W-1:0] rem;
        wa  = a;
        wb  = b;
        wm  = m;
        rem = (wa * wb) % wm;
        return rem[W-1:0];
    endfunction

    function automatic logic [W-1:0] power_mod(input logic [W-1:0] base_value,
                                               input logic [W-1:0] exponent,
                                               input logic [W-1:0] m);
        logic [W-1:0] square;
        logic [W-1:0] acc;
        logic [W-1:0] bits_left;
        square    = base_value % m;
        acc       = W'(1);
        bits_left = exponent;
        // The accumulator starts at one unreduced, so a zero exponent gives one for any modulus.
        while (bits_left != '0) begin
            if (bits_left[0]) begin
                acc = mul_reduce(acc, square, m);
            end
            square    = mul_reduce(square, square, m);
            bits_left = bits_left >> 1;
        end
        return acc;
    endfunction

    function automatic logic [W-1:0] rand_field();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[W-1:0];
    endfunction

    // Mostly short exponents to keep the run short; a few span the full width.
    function automatic logic [W-1:0] pick_exponent();
        int           sel;
        logic [W-1:0] mask;
        sel = $urandom_range(0, 99);
        if (sel < 5) return '0;
        if (sel < 13) return rand_field();
        mask = (W'(1) << $urandom_range(1, 14)) - W'(1);
        return rand_field() & mask;
    endfunction

    function automatic logic [W-1:0] pick_base();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) return W'($urandom_range(0, 3));
        if (sel < 20) return modulus_shadow - W'($urandom_range(0, 2));
        if (sel < 25) return ALL_ONES;
        return rand_field();
    endfunction

    function automatic int pick_gap(input bit steady);
        int sel;
        if (steady) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(12, 80);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_item(input logic [W-1:0] base_value, input logic [W-1:0] exponent,
                             input logic known, input logic [W-1:0] typed_power);
        int           gap;
        t_power_entry entry;
        if ($urandom_range(0, 11) == 0) send_steady = ~send_steady;
        gap = pick_gap(send_steady);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.base_value <= base_value;
        in_ch.exponent   <= exponent;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        entry.base_value = base_value;
        entry.exponent   = exponent;
        entry.modulus    = modulus_shadow;
        entry.power      = known ? typed_power : power_mod(base_value, exponent, modulus_shadow);
        pending_powers.push_back(entry);
    endtask

    // The modulus is only changed once every result of the previous phase is back.
    task automatic write_modulus(input logic [W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        modulus_shadow = (value == '0) ? W'(1) : value;
    endtask

    always @(posedge i_clk) begin : check_results
        t_power_entry head;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected power_result %0d", out_ch.power_result));
            end else begin
                head = pending_powers.pop_front();
                if (out_ch.power_result !== head.power) begin
                    report_mismatch($sformatf(
                        "power_result %0d, expected %0d (base %0d, exponent %0d, modulus %0d)",
                        out_ch.power_result, head.power, head.base_value, head.exponent,
                        head.modulus));
                end
            end
        end
    end

    initial begin : drain_results
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                // Long back-pressure so the core fills up and stops taking items.
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 15) == 0) recv_steady = ~recv_steady;
                stall = pick_gap(recv_steady);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("modular_exponentiation_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_stim_row    directed_rows [N_DIRECTED];
        logic [W-1:0] phase_moduli [N_PHASES];
        int           phase_items [N_PHASES];

        error_count    = 0;
        hold_request   = 1'b0;
        send_steady    = 1'b0;
        recv_steady    = 1'b0;
        modulus_shadow = MOD_AT_RESET;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.base_value <= '0;
        in_ch.exponent   <= '0;

        directed_rows = '{
            '{W'(0),            W'(0),     1'b1, W'(1)},
            '{W'(0),            W'(1),     1'b1, W'(0)},
            '{ALL_ONES,         W'(0),     1'b1, W'(1)},
            '{W'(1),            ALL_ONES,  1'b1, W'(1)},
            '{MOD_AT_RESET,     W'(5),     1'b1, W'(0)},
            '{MOD_AT_RESET - 1, W'(2),     1'b1, W'(1)},
            '{MOD_AT_RESET - 1, W'(3),     1'b1, MOD_AT_RESET - 1},
            '{W'(2),            W'(10),    1'b1, W'(1024)},
            '{MOD_AT_RESET + 1, ALL_ONES,  1'b1, W'(1)},
            '{ALL_ONES,         W'(1),     1'b0, W'(0)},
            '{W'(2),            W'(62),    1'b0, W'(0)},
            '{W'(3),            W'(1) << (W - 1), 1'b0, W'(0)},
            '{ODD_BITS,         EVEN_BITS, 1'b0, W'(0)},
            '{EVEN_BITS,        ODD_BITS,  1'b0, W'(0)},
            '{W'(12345),        W'(65537), 1'b0, W'(0)}
        };

        // Modulus zero is stored as one; the others cover the top value and small and wide ones.
        phase_moduli = '{'0, ALL_ONES, W'(2), rand_field(), W'($urandom_range(3, 1 << 20))};
        phase_items  = '{8, 25, 8, 30, 20};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first phase runs on the modulus left by reset.
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].base_value, directed_rows[i].exponent,
                      directed_rows[i].known, directed_rows[i].power);
        end
        repeat (10) send_item(pick_base(), pick_exponent(), 1'b0, '0);

        for (int p = 0; p < N_PHASES; p++) begin
            write_modulus(phase_moduli[p]);
            if (p == N_PHASES - 1) hold_request = 1'b1;
            repeat (phase_items[p]) send_item(pick_base(), pick_exponent(), 1'b0, '0);
        end

        in_ch.valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_powers.size() == 0) begin
            $display("modular_exponentiation_core: match");
        end else begin
            $display("modular_exponentiation_core: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_in_if.sv
rtl/core/mexp_out_if.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_core.sv
tb/tb_modular_exponentiation_core.sv
